// ===== rtl/tvs_pkg.sv =====
// Shared types and constants for the tuning verdict stabilizer.
`default_nettype none

package tvs_pkg;

    // Field widths fixed by the interface
    localparam int CENTS_W    = 14;
    localparam int BLOCK_W    = 14;
    localparam int TOL_W      = 11;
    localparam int THRESH_W   = 24;
    localparam int BAND_W     = TOL_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Displayed / candidate zone codes
    typedef enum logic [1:0] {
        ZONE_NONE  = 2'd0,
        ZONE_RAISE = 2'd1,
        ZONE_TUNE  = 2'd2,
        ZONE_LOWER = 2'd3
    } t_zone;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DB  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd5;

    // Register reset values
    localparam logic [TOL_W-1:0]    RST_TOLERANCE  = 11'd32;
    localparam logic [TOL_W-1:0]    RST_HYSTERESIS = 11'd24;
    localparam logic [THRESH_W-1:0] RST_HOLD       = 24'd62400;
    localparam logic [THRESH_W-1:0] RST_ENTER_DB   = 24'd1440;
    localparam logic [THRESH_W-1:0] RST_SWITCH_DB  = 24'd5760;
    localparam logic [THRESH_W-1:0] RST_RELEASE    = 24'd19200;

    // Configuration register bank
    typedef struct packed {
        logic [TOL_W-1:0]    tolerance;
        logic [TOL_W-1:0]    hysteresis;
        logic [THRESH_W-1:0] hold;
        logic [THRESH_W-1:0] enter_wait;
        logic [THRESH_W-1:0] switch_wait;
        logic [THRESH_W-1:0] release_len;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/tvs_step.sv =====
// Combinational next-state logic for one block reading.
`default_nettype none

module tvs_step #(
    parameter int COUNT_WIDTH = 24,
    parameter int MAX_BLOCK   = 8192
) (
    input  tvs_pkg::t_cfg                     i_cfg,
    input  logic                              i_voiced,
    input  logic signed [tvs_pkg::CENTS_W-1:0] i_cents_dev,
    input  logic [tvs_pkg::BLOCK_W-1:0]       i_block_len,
    input  tvs_pkg::t_zone                    i_shown,
    input  tvs_pkg::t_zone                    i_cand,
    input  logic [COUNT_WIDTH-1:0]            i_cand_cnt,
    input  logic [COUNT_WIDTH-1:0]            i_sil_cnt,
    input  logic [COUNT_WIDTH-1:0]            i_tune_cnt,
    output tvs_pkg::t_zone                    o_shown,
    output tvs_pkg::t_zone                    o_cand,
    output logic [COUNT_WIDTH-1:0]            o_cand_cnt,
    output logic [COUNT_WIDTH-1:0]            o_sil_cnt,
    output logic [COUNT_WIDTH-1:0]            o_tune_cnt,
    output logic                              o_entered
);

    localparam int BW      = tvs_pkg::BLOCK_W;
    localparam int CMP_W   = (COUNT_WIDTH > tvs_pkg::THRESH_W) ? COUNT_WIDTH
                                                              : tvs_pkg::THRESH_W;
    localparam int LEN_MAX = (1 << BW) - 1;
    localparam int MAX_LEN = (MAX_BLOCK > LEN_MAX) ? LEN_MAX : MAX_BLOCK;
    localparam int MB_W    = 17;

    // Saturating add of a block length to a counter
    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [BW-1:0]          b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
        sat_add = s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    logic [BW-1:0]              len;
    logic [COUNT_WIDTH-1:0]     tune_acc;
    logic [COUNT_WIDTH-1:0]     sil_acc;
    logic [COUNT_WIDTH-1:0]     cand_acc;
    logic [tvs_pkg::BAND_W-1:0] band;
    logic [tvs_pkg::CENTS_W:0]  cents_ext;
    logic [tvs_pkg::CENTS_W:0]  mag;
    tvs_pkg::t_zone             raw;
    logic                       latched;
    logic [CMP_W-1:0]           need;

    // Block length clamp to MAX_BLOCK; sat_add saturates, so adding len never wraps a counter
    assign len = ({{(MB_W-BW){1'b0}}, i_block_len} > MB_W'(MAX_BLOCK)) ? BW'(MAX_LEN)
                                                                       : i_block_len;

    assign tune_acc = (i_shown == tvs_pkg::ZONE_TUNE) ? sat_add(i_tune_cnt, len)
                                                      : i_tune_cnt;
    assign sil_acc  = sat_add(i_sil_cnt, len);
    assign cand_acc = sat_add(i_cand_cnt, len);

    // Band widens by the hysteresis margin while in tune
    assign band = {1'b0, i_cfg.tolerance} +
                  ((i_shown == tvs_pkg::ZONE_TUNE) ? {1'b0, i_cfg.hysteresis}
                                                   : {tvs_pkg::BAND_W{1'b0}});
    assign cents_ext = {i_cents_dev[tvs_pkg::CENTS_W-1], i_cents_dev};
    assign mag       = cents_ext[tvs_pkg::CENTS_W] ? (~cents_ext + 1'b1) : cents_ext;

    // Raw zone of this block
    always_comb begin
        if (i_voiced) begin
            if (mag <= (tvs_pkg::CENTS_W+1)'(band)) begin
                raw = tvs_pkg::ZONE_TUNE;
            end else if (i_cents_dev[tvs_pkg::CENTS_W-1]) begin
                raw = tvs_pkg::ZONE_RAISE;
            end else begin
                raw = tvs_pkg::ZONE_LOWER;
            end
        end else begin
            raw = (CMP_W'(sil_acc) < CMP_W'(i_cfg.release_len)) ? i_shown
                                                                 : tvs_pkg::ZONE_NONE;
        end
    end

    assign latched = (i_shown == tvs_pkg::ZONE_TUNE) &&
                     (CMP_W'(tune_acc) < CMP_W'(i_cfg.hold));
    assign need    = (raw == tvs_pkg::ZONE_TUNE) ? CMP_W'(i_cfg.enter_wait)
                                                 : CMP_W'(i_cfg.switch_wait);

    // Candidate tracking and adoption
    always_comb begin
        o_shown    = i_shown;
        o_cand     = i_cand;
        o_cand_cnt = i_cand_cnt;
        o_tune_cnt = tune_acc;
        o_sil_cnt  = i_voiced ? {COUNT_WIDTH{1'b0}} : sil_acc;
        if (latched && raw != tvs_pkg::ZONE_TUNE) begin
            o_cand     = tvs_pkg::ZONE_NONE;
            o_cand_cnt = '0;
        end else if (raw == i_shown) begin
            o_cand_cnt = '0;
        end else if (raw == i_cand) begin
            o_cand_cnt = cand_acc;
            if (CMP_W'(cand_acc) >= need) begin
                o_shown    = raw;
                o_cand_cnt = '0;
                if (raw == tvs_pkg::ZONE_TUNE) begin
                    o_tune_cnt = '0;
                end
            end
        end else begin
            o_cand     = raw;
            o_cand_cnt = COUNT_WIDTH'(len);
        end
    end

    assign o_entered = (o_shown == tvs_pkg::ZONE_TUNE) && (i_shown != tvs_pkg::ZONE_TUNE);

endmodule

`default_nettype wire

// ===== rtl/tuning_verdict_stabilizer.sv =====
// Top level: input register, verdict state, result register and config bank.
//
//  channel | valid        | stall        | beat payload
//  --------+--------------+--------------+----------------------------------------------
//  in      | i_in_valid   | o_in_stall   | i_voiced, i_cents_dev, i_block_len
//  out     | o_out_valid  | i_out_stall  | o_zone, o_*_lamp, o_entered_in_tune
//  cfg     | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle sustained while the output is not stalled; a beat passes through the
//  input register, then the state update into the result register, before its result shows.
//  Reset is synchronous and active low; it restores register defaults and clears
//  the verdict state. A stall on the output holds the result register and the
//  state; the input register still takes one more beat if it is empty.
`default_nettype none

module tuning_verdict_stabilizer #(
    parameter int COUNT_WIDTH = 24,
    parameter int MAX_BLOCK   = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_voiced,
    input  logic signed [tvs_pkg::CENTS_W-1:0]  i_cents_dev,
    input  logic [tvs_pkg::BLOCK_W-1:0]         i_block_len,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_zone,
    output logic                                o_raise_lamp,
    output logic                                o_in_tune_lamp,
    output logic                                o_lower_lamp,
    output logic                                o_entered_in_tune,
    input  logic                                i_cfg_we,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tvs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    tvs_pkg::t_cfg r_cfg;

    logic                              r_in_valid;
    logic                              r_has_note;
    logic signed [tvs_pkg::CENTS_W-1:0] r_cents_dev;
    logic [tvs_pkg::BLOCK_W-1:0]       r_block_len;

    tvs_pkg::t_zone                    r_shown;
    tvs_pkg::t_zone                    r_cand;
    logic [COUNT_WIDTH-1:0]            r_cand_cnt;
    logic [COUNT_WIDTH-1:0]            r_sil_cnt;
    logic [COUNT_WIDTH-1:0]            r_tune_cnt;

    logic                              r_out_valid;
    tvs_pkg::t_zone                    r_zone;
    logic                              r_entered;

    tvs_pkg::t_zone                    n_shown;
    tvs_pkg::t_zone                    n_cand;
    logic [COUNT_WIDTH-1:0]            n_cand_cnt;
    logic [COUNT_WIDTH-1:0]            n_sil_cnt;
    logic [COUNT_WIDTH-1:0]            n_tune_cnt;
    logic                              n_entered;

    logic out_free;
    logic advance;
    logic in_take;

    // Handshake: result register frees up when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance   <= tvs_pkg::RST_TOLERANCE;
            r_cfg.hysteresis  <= tvs_pkg::RST_HYSTERESIS;
            r_cfg.hold        <= tvs_pkg::RST_HOLD;
            r_cfg.enter_wait  <= tvs_pkg::RST_ENTER_DB;
            r_cfg.switch_wait <= tvs_pkg::RST_SWITCH_DB;
            r_cfg.release_len <= tvs_pkg::RST_RELEASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tvs_pkg::CFG_TOLERANCE: begin
                    r_cfg.tolerance <= i_cfg_wdata[tvs_pkg::TOL_W-1:0];
                end
                tvs_pkg::CFG_HYSTERESIS: begin
                    r_cfg.hysteresis <= i_cfg_wdata[tvs_pkg::TOL_W-1:0];
                end
                tvs_pkg::CFG_HOLD:      r_cfg.hold        <= i_cfg_wdata;
                tvs_pkg::CFG_ENTER_DB:  r_cfg.enter_wait  <= i_cfg_wdata;
                tvs_pkg::CFG_SWITCH_DB: r_cfg.switch_wait <= i_cfg_wdata;
                tvs_pkg::CFG_RELEASE:   r_cfg.release_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_has_note  <= i_voiced;
            r_cents_dev <= i_cents_dev;
            r_block_len <= i_block_len;
        end
    end

    // Verdict update
    tvs_step #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_voiced    (r_has_note),
        .i_cents_dev (r_cents_dev),
        .i_block_len (r_block_len),
        .i_shown     (r_shown),
        .i_cand      (r_cand),
        .i_cand_cnt  (r_cand_cnt),
        .i_sil_cnt   (r_sil_cnt),
        .i_tune_cnt  (r_tune_cnt),
        .o_shown     (n_shown),
        .o_cand      (n_cand),
        .o_cand_cnt  (n_cand_cnt),
        .o_sil_cnt   (n_sil_cnt),
        .o_tune_cnt  (n_tune_cnt),
        .o_entered   (n_entered)
    );

    // Verdict state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown    <= tvs_pkg::ZONE_NONE;
            r_cand     <= tvs_pkg::ZONE_NONE;
            r_cand_cnt <= '0;
            r_sil_cnt  <= '0;
            r_tune_cnt <= '0;
        end else if (advance) begin
            r_shown    <= n_shown;
            r_cand     <= n_cand;
            r_cand_cnt <= n_cand_cnt;
            r_sil_cnt  <= n_sil_cnt;
            r_tune_cnt <= n_tune_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_zone    <= n_shown;
            r_entered <= n_entered;
        end
    end

    // Output decode
    assign o_out_valid       = r_out_valid;
    assign o_zone            = r_zone;
    assign o_raise_lamp      = (r_zone == tvs_pkg::ZONE_RAISE);
    assign o_in_tune_lamp    = (r_zone == tvs_pkg::ZONE_TUNE);
    assign o_lower_lamp      = (r_zone == tvs_pkg::ZONE_LOWER);
    assign o_entered_in_tune = r_entered;

    // Checks
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_shown))
        else $error("shown zone moved without a beat");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_zone == r_shown))
        else $error("result zone differs from shown zone");

    a_entered_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_entered) |=> ($past(r_shown) != tvs_pkg::ZONE_TUNE) &&
                                   (r_shown == tvs_pkg::ZONE_TUNE))
        else $error("entered flag without a rise into in tune");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid && (r_shown == tvs_pkg::ZONE_NONE))
        else $error("reset left state behind");

endmodule

`default_nettype wire
